### sv/lidar_scan_direction_generator_macros.svh
// ---------------------------------------------------------------------------
// Lidar scan direction generator assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LIDAR_SCAN_DIRECTION_GENERATOR_MACROS_SVH
`define LIDAR_SCAN_DIRECTION_GENERATOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define LSDG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds after the antecedent, delayed by dly.
`define LSDG_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### sv/lsdg_pkg.sv
// ---------------------------------------------------------------------------
// Lidar scan direction generator package
// Types, register codes and fixed constants shared by the block's modules.
// ---------------------------------------------------------------------------
package lsdg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT  = 3'd0,
    REG_POINTS_PER_CH  = 3'd1,
    REG_VERTICAL_LOWER = 3'd2,
    REG_VERTICAL_UPPER = 3'd3,
    REG_HORIZONTAL_FOV = 3'd4
  } cfg_reg_e;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]         channel_count;
    logic [12:0]        points_per_channel;
    logic signed [15:0] vertical_lower;
    logic signed [15:0] vertical_upper;
    logic [15:0]        horizontal_fov;
  } cfg_t;

  // Item handed from the front end to the back end through the queue.
  typedef struct packed {
    logic        err;
    logic [15:0] el_ang;
    logic [15:0] az_ang;
  } front_item_t;

  // Divider widths: dividend bits (one pipeline stage each) and divisor bits.
  localparam int DIV_BITS = 29;
  localparam int DEN_BITS = 13;

  // Angles in 1/128 degree.
  localparam logic [16:0] FULL_TURN    = 17'd46080;
  localparam logic [16:0] HALF_TURN    = 17'd23040;
  localparam logic [16:0] QUARTER_TURN = 17'd11520;
  localparam logic [16:0] THREE_QUARTER_TURN = 17'd34560;

  // CORDIC datapath width and start value (Q4.30).
  localparam int XW = 34;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in units of 2^-23 degree.
  localparam int ATAN_TAB [24] = '{
    377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
    7509261, 3754860, 1877459, 938733, 469367, 234683,
    117342, 58671, 29335, 14668, 7334, 3667,
    1833, 917, 458, 229, 115, 57
  };

endpackage

### sv/lsdg_div.sv
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per pipeline stage, with a side tag.
// ---------------------------------------------------------------------------
module lsdg_div #(
  parameter int N  = 29,
  parameter int M  = 13,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [N-1:0]  num,
  input  logic [M-1:0]  den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [N-1:0]  quo,
  output logic [TW-1:0] tag_out
);

  // Stage registers; index 0 is the input.
  logic [N-1:0]  dq    [N+1];
  logic [M-1:0]  rem   [N+1];
  logic [M-1:0]  den_s [N+1];
  logic [TW-1:0] tag_s [N+1];
  logic [N-1:0]  vld;

  assign dq[0]    = num;
  assign rem[0]   = '0;
  assign den_s[0] = den;
  assign tag_s[0] = tag_in;

  // Valid shift line.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  // One restoring step per stage: shift in the next dividend bit, subtract if it fits.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [M:0] trial;
    logic       ge;

    assign trial = {rem[s], dq[s][N-1]};
    assign ge    = (trial >= {1'b0, den_s[s]});

    always_ff @(posedge clk) begin
      rem[s+1]   <= ge ? M'(trial - {1'b0, den_s[s]}) : trial[M-1:0];
      dq[s+1]    <= {dq[s][N-2:0], ge};
      den_s[s+1] <= den_s[s];
      tag_s[s+1] <= tag_s[s];
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = dq[N];
  assign tag_out   = tag_s[N];

endmodule

### sv/lsdg_front.sv
// ---------------------------------------------------------------------------
// Front end
// Checks indexes, forms elevation and azimuth numerators, divides and reduces
// both angles to one turn.
// ---------------------------------------------------------------------------
module lsdg_front #(
  parameter int MAX_CHANNELS = 128,
  parameter int MAX_POINTS   = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [6:0]            channel_index,
  input  logic [11:0]           point_index,
  input  lsdg_pkg::cfg_t        cfg,
  output logic                  out_valid,
  output lsdg_pkg::front_item_t out_item
);
  import lsdg_pkg::*;

  logic [7:0]         nch;
  logic [12:0]        npt;
  logic               idx_err;
  logic signed [16:0] diff;
  logic signed [24:0] prod_n;
  logic [27:0]        prod_m;

  logic               s1_valid;
  logic               s1_err;
  logic               s1_single;
  logic signed [24:0] s1_prod_n;
  logic [27:0]        s1_prod_m;
  logic [7:0]         s1_d;
  logic [12:0]        s1_npt;

  logic [23:0]          nabs;
  logic [DIV_BITS-1:0]  num_el;
  logic [DIV_BITS-1:0]  num_az;
  logic                 el_v;
  logic                 az_v;
  logic [DIV_BITS-1:0]  q_el;
  logic [DIV_BITS-1:0]  q_az;
  logic [1:0]           el_tag;
  logic                 az_err;

  logic [16:0]        qm;
  logic signed [18:0] qs;
  logic signed [18:0] el;
  logic signed [18:0] el_sel;
  logic [18:0]        el_red;
  logic [16:0]        qa;
  logic [16:0]        az_red;

  // Counts limited by the configured maximums, and the range check.
  always_comb begin
    nch = (32'(cfg.channel_count) < MAX_CHANNELS) ? cfg.channel_count : 8'(MAX_CHANNELS);
    npt = (32'(cfg.points_per_channel) < MAX_POINTS) ?
          cfg.points_per_channel : 13'(MAX_POINTS);
    idx_err = ({1'b0, channel_index} >= nch) || ({1'b0, point_index} >= npt);
    diff    = $signed({cfg.vertical_upper[15], cfg.vertical_upper}) -
              $signed({cfg.vertical_lower[15], cfg.vertical_lower});
    prod_n  = diff * $signed({1'b0, channel_index});
    prod_m  = 28'(point_index) * 28'(cfg.horizontal_fov);
  end

  // First stage: products and divisors.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_err    <= idx_err;
    s1_single <= (nch == 8'd1);
    s1_prod_n <= prod_n;
    s1_prod_m <= prod_m;
    s1_d      <= nch - 8'd1;
    s1_npt    <= npt;
  end

  // Rounded numerators: magnitude plus half the divisor.
  always_comb begin
    nabs   = s1_prod_n[24] ? 24'(-s1_prod_n) : 24'(s1_prod_n);
    num_el = DIV_BITS'(nabs) + DIV_BITS'(s1_d >> 1);
    num_az = DIV_BITS'(s1_prod_m) + DIV_BITS'(s1_npt >> 1);
  end

  lsdg_div #(.N(DIV_BITS), .M(DEN_BITS), .TW(2)) u_div_el (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .num       (num_el),
    .den       (DEN_BITS'(s1_d)),
    .tag_in    ({s1_single, s1_prod_n[24]}),
    .out_valid (el_v),
    .quo       (q_el),
    .tag_out   (el_tag)
  );

  lsdg_div #(.N(DIV_BITS), .M(DEN_BITS), .TW(1)) u_div_az (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .num       (num_az),
    .den       (s1_npt),
    .tag_in    (s1_err),
    .out_valid (az_v),
    .quo       (q_az),
    .tag_out   (az_err)
  );

  // Signed elevation and reduction of both angles into one turn.
  always_comb begin
    qm     = q_el[16:0];
    qs     = el_tag[0] ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
    el     = $signed({{3{cfg.vertical_lower[15]}}, cfg.vertical_lower}) + qs;
    el_sel = el_tag[1] ? 19'sd0 : el;
    el_red = el_sel[18] ? 19'(el_sel + $signed({2'b00, FULL_TURN})) : 19'(el_sel);
    qa     = q_az[16:0];
    az_red = (qa >= FULL_TURN) ? qa - FULL_TURN : qa;
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= el_v && az_v;
    end
    out_item.err    <= az_err;
    out_item.el_ang <= el_red[15:0];
    out_item.az_ang <= az_red[15:0];
  end

endmodule

### sv/lsdg_queue.sv
// ---------------------------------------------------------------------------
// Decoupling queue
// Two-entry queue between the front end and the back end; the back end takes
// one transfer every cycle the queue holds an entry.
// ---------------------------------------------------------------------------
module lsdg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lsdg_pkg::front_item_t push_item,
  output logic                  pop,
  output lsdg_pkg::front_item_t pop_item,
  output logic                  full
);
  import lsdg_pkg::*;

  front_item_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign pop      = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign pop_item = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/lsdg_cordic.sv
// ---------------------------------------------------------------------------
// CORDIC sine and cosine
// Folds an angle into [-90, 90] degrees, then runs one rotation per stage.
// ---------------------------------------------------------------------------
module lsdg_cordic #(
  parameter int STEPS = 16
) (
  input  logic                           clk,
  input  logic [15:0]                    ang,
  output logic signed [lsdg_pkg::XW-1:0] cos_out,
  output logic signed [lsdg_pkg::XW-1:0] sin_out,
  output logic                           neg_out
);
  import lsdg_pkg::*;

  logic signed [XW-1:0] x   [STEPS+1];
  logic signed [XW-1:0] y   [STEPS+1];
  logic signed [XW-1:0] z   [STEPS+1];
  logic                 neg [STEPS+1];

  logic [16:0]          a;
  logic signed [16:0]   af;
  logic                 fold_neg;
  logic signed [XW-1:0] z0;

  // Fold into the right half plane; the far half negates both outputs.
  always_comb begin
    a        = {1'b0, ang};
    fold_neg = 1'b0;
    af       = $signed(a);
    if (a > QUARTER_TURN && a <= THREE_QUARTER_TURN) begin
      af       = $signed(a - HALF_TURN);
      fold_neg = 1'b1;
    end else if (a > THREE_QUARTER_TURN) begin
      af = $signed(a - FULL_TURN);
    end
    z0 = XW'(af) <<< 16;
  end

  always_ff @(posedge clk) begin
    x[0]   <= CORDIC_GAIN;
    y[0]   <= '0;
    z[0]   <= z0;
    neg[0] <= fold_neg;
  end

  // Rotation stages.
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [XW-1:0] atan_i;
    assign atan_i = XW'(ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (!z[i][XW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_i;
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_i;
      end
      neg[i+1] <= neg[i];
    end
  end

  assign cos_out = x[STEPS];
  assign sin_out = y[STEPS];
  assign neg_out = neg[STEPS];

endmodule

### sv/lsdg_back.sv
// ---------------------------------------------------------------------------
// Back end
// Two CORDIC pipelines, the direction products, rounding and saturation.
// ---------------------------------------------------------------------------
module lsdg_back #(
  parameter int STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  lsdg_pkg::front_item_t in_item,
  output logic                  result_valid,
  output logic signed [15:0]    dir_x,
  output logic signed [15:0]    dir_y,
  output logic signed [15:0]    dir_z,
  output logic                  index_error
);
  import lsdg_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  logic signed [XW-1:0] ce;
  logic signed [XW-1:0] se;
  logic signed [XW-1:0] ca;
  logic signed [XW-1:0] sa;
  logic                 ne;
  logic                 na;

  logic [STEPS:0] vld;
  logic [STEPS:0] err;

  logic               p_valid;
  logic               p_err;
  logic               p_sgn;
  logic               p_nz;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [XW-1:0] pz;

  logic signed [64:0] rx;
  logic signed [64:0] ry;
  logic signed [XW:0] rz;

  lsdg_cordic #(.STEPS(STEPS)) u_cordic_el (
    .clk     (clk),
    .ang     (in_item.el_ang),
    .cos_out (ce),
    .sin_out (se),
    .neg_out (ne)
  );

  lsdg_cordic #(.STEPS(STEPS)) u_cordic_az (
    .clk     (clk),
    .ang     (in_item.az_ang),
    .cos_out (ca),
    .sin_out (sa),
    .neg_out (na)
  );

  // Valid and error flags travel alongside the CORDIC stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STEPS-1:0], in_valid};
    end
    err <= {err[STEPS-1:0], in_item.err};
  end

  // Products of the cosine of elevation with the azimuth terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= vld[STEPS];
    end
    p_err <= err[STEPS];
    p_sgn <= ne ^ na;
    p_nz  <= ne;
    px    <= $signed(ce[31:0]) * $signed(ca[31:0]);
    py    <= $signed(ce[31:0]) * $signed(sa[31:0]);
    pz    <= se;
  end

  // Apply fold signs together with the rounding offset.
  always_comb begin
    rx = p_sgn ? (65'sd17592186044416 - $signed({px[63], px}))
               : ($signed({px[63], px}) + 65'sd17592186044416);
    ry = p_sgn ? (65'sd17592186044416 - $signed({py[63], py}))
               : ($signed({py[63], py}) + 65'sd17592186044416);
    rz = p_nz ? ((XW+1)'(16384) - $signed({pz[XW-1], pz}))
              : ($signed({pz[XW-1], pz}) + (XW+1)'(16384));
  end

  // Output register; an out-of-range index gives zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= p_valid;
    end
    index_error <= p_err;
    dir_x <= p_err ? 16'sd0 : sat16($signed(rx[64:45]));
    dir_y <= p_err ? 16'sd0 : sat16($signed(ry[64:45]));
    dir_z <= p_err ? 16'sd0 : sat16($signed(rz[XW:15]));
  end

endmodule

### sv/lidar_scan_direction_generator.sv
// ---------------------------------------------------------------------------
// Lidar scan direction generator
// Unit beam direction in Q1.15 from a channel index and a point index.
// ---------------------------------------------------------------------------
// A beam is taken at every clock edge where start is high and busy is low, so
// one direction can be issued per clock. Each result appears on dir_x, dir_y,
// dir_z and index_error for exactly one cycle with result_valid high, in the
// order the beams were taken; the receiver cannot stall it. The path runs
// through the two 29-stage bit-per-stage dividers in the front end, the
// decoupling queue and the CORDIC pipelines in the back end. Registers are
// written through cfg_we, cfg_index and cfg_data and should change only while
// no beam is in flight.
module lidar_scan_direction_generator #(
  parameter int MAX_CHANNELS = 128,
  parameter int MAX_POINTS   = 4096,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [6:0]         channel_index,
  input  logic [11:0]        point_index,
  output logic               result_valid,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  output logic               index_error
);
  import lsdg_pkg::*;
  `include "lidar_scan_direction_generator_macros.svh"

  localparam int LATENCY = DIV_BITS + CORDIC_STEPS + 6;

  cfg_t        cfg;
  logic        accept;
  logic        f_valid;
  front_item_t f_item;
  logic        q_pop;
  front_item_t q_item;
  logic        q_full;

  assign busy   = q_full || rst;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count      <= 8'd16;
      cfg.points_per_channel <= 13'd1800;
      cfg.vertical_lower     <= -16'sd1920;
      cfg.vertical_upper     <= 16'sd1920;
      cfg.horizontal_fov     <= 16'd46080;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CHANNEL_COUNT:  cfg.channel_count      <= cfg_data[7:0];
        REG_POINTS_PER_CH:  cfg.points_per_channel <= cfg_data[12:0];
        REG_VERTICAL_LOWER: cfg.vertical_lower     <= $signed(cfg_data);
        REG_VERTICAL_UPPER: cfg.vertical_upper     <= $signed(cfg_data);
        REG_HORIZONTAL_FOV: cfg.horizontal_fov     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lsdg_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_POINTS(MAX_POINTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .channel_index (channel_index),
    .point_index   (point_index),
    .cfg           (cfg),
    .out_valid     (f_valid),
    .out_item      (f_item)
  );

  lsdg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full)
  );

  lsdg_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_pop),
    .in_item      (q_item),
    .result_valid (result_valid),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .index_error  (index_error)
  );

  // Checks on the pipeline as a whole.
  `LSDG_ASSERT_DELAY(a_fixed_latency, accept, LATENCY, result_valid, "result missing")
  `LSDG_ASSERT_IMPL(a_err_zero, result_valid && index_error, dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0, "error result not zero")
  `LSDG_ASSERT_IMPL(a_queue_not_full, f_valid, !q_full, "queue overrun")

endmodule
